// ===== hdl/assert_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock edge, off while reset is asserted.
`define ASSERT_CLK(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");

// Concurrent check that also runs through reset.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) (prop)) \
        else $error("assertion failed");

`endif

// ===== hdl/dna_pkg.sv =====
package dna_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

    // Derived widths
    localparam int WIDE_BITS = 2 * WORD_BITS + 1;          // exact sums of products
    localparam int PROD_BITS = 2 * WORD_BITS;              // one product
    localparam int NUM_BITS  = 2 * WORD_BITS + FRAC_BITS;  // scaled dividend
    localparam int DEN_BITS  = 2 * WORD_BITS;              // divisor, up to b squared
    localparam int QUO_BITS  = WORD_BITS + 1;              // quotient bits produced
    localparam int MAG_BITS  = WORD_BITS + 1;              // magnitude of one word

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIVZ = 2'd2
    } status_t;

    localparam logic signed [WORD_BITS-1:0] WORD_MAX_C = {1'b0, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WORD_BITS-1:0] WORD_MIN_C = {1'b1, {(WORD_BITS-1){1'b0}}};

    localparam logic signed [WIDE_BITS-1:0] WIDE_MAX_C =
        {{(WIDE_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    localparam logic signed [WIDE_BITS-1:0] WIDE_MIN_C = ~WIDE_MAX_C;

    localparam logic [QUO_BITS-1:0] LIM_POS_C =
        {{(QUO_BITS-WORD_BITS+1){1'b0}}, {(WORD_BITS-1){1'b1}}};
    localparam logic [QUO_BITS-1:0] LIM_NEG_C = LIM_POS_C + 1'b1;

    // Result carried past the divider for non-dividing operations
    typedef struct packed {
        logic                        is_div;
        logic signed [WORD_BITS-1:0] val;
        logic signed [WORD_BITS-1:0] der;
        status_t                     status;
    } carry_t;

    // Operands of one division lane
    typedef struct packed {
        logic [NUM_BITS-1:0] numr;
        logic [DEN_BITS-1:0] den;
        logic                neg;
    } nlane_t;

    // Working state of one division lane
    typedef struct packed {
        logic [DEN_BITS-1:0] rem;
        logic [QUO_BITS-1:0] nlow;
        logic [QUO_BITS-1:0] quo;
        logic [DEN_BITS-1:0] den;
        logic                neg;
        logic                ovf;
    } lane_t;

    typedef struct packed {
        logic                        sat;
        logic signed [WORD_BITS-1:0] val;
    } clamp_t;

    // Clamp an exact wide value to one word
    function automatic clamp_t clamp_word(input logic signed [WIDE_BITS-1:0] v);
        clamp_t r;
        r.sat = 1'b0;
        r.val = v[WORD_BITS-1:0];
        if (v > WIDE_MAX_C) begin
            r.sat = 1'b1;
            r.val = WORD_MAX_C;
        end else if (v < WIDE_MIN_C) begin
            r.sat = 1'b1;
            r.val = WORD_MIN_C;
        end
        return r;
    endfunction

    // Magnitude of a signed word
    function automatic logic [MAG_BITS-1:0] word_mag(input logic signed [WORD_BITS-1:0] v);
        logic [MAG_BITS-1:0] x;
        x = {v[WORD_BITS-1], v};
        return v[WORD_BITS-1] ? (~x + 1'b1) : x;
    endfunction

    // Split the dividend: high part seeds the remainder, or flags overflow
    function automatic lane_t div_init(input nlane_t n);
        lane_t l;
        l.rem  = DEN_BITS'(n.numr[NUM_BITS-1:QUO_BITS]);
        l.nlow = n.numr[QUO_BITS-1:0];
        l.quo  = '0;
        l.den  = n.den;
        l.neg  = n.neg;
        l.ovf  = (DEN_BITS'(n.numr[NUM_BITS-1:QUO_BITS]) >= n.den);
        return l;
    endfunction

    // One restoring division step
    function automatic lane_t div_step(input lane_t l);
        lane_t               r;
        logic [DEN_BITS:0]   trial;
        logic                qbit;
        r     = l;
        trial = {l.rem, l.nlow[QUO_BITS-1]};
        qbit  = (trial >= {1'b0, l.den});
        if (qbit) begin
            trial = trial - {1'b0, l.den};
        end
        r.rem  = trial[DEN_BITS-1:0];
        r.nlow = {l.nlow[QUO_BITS-2:0], 1'b0};
        r.quo  = {l.quo[QUO_BITS-2:0], qbit};
        return r;
    endfunction

    // Saturate the quotient magnitude and apply the sign
    function automatic clamp_t div_finish(input lane_t l);
        clamp_t              r;
        logic [QUO_BITS-1:0] lim;
        logic [QUO_BITS-1:0] q;
        logic [QUO_BITS-1:0] nq;
        lim   = l.neg ? LIM_NEG_C : LIM_POS_C;
        q     = l.quo;
        r.sat = 1'b0;
        if (l.ovf || (q > lim)) begin
            r.sat = 1'b1;
            q     = lim;
        end
        nq    = ~q + 1'b1;
        r.val = l.neg ? nq[WORD_BITS-1:0] : q[WORD_BITS-1:0];
        return r;
    endfunction

endpackage

// ===== hdl/dual_number_alu_unit.sv =====
// Dual-number ALU, signed Q16.16. Each transfer carries two dual operands
// (value, derivative) and an operation (add, subtract, multiply, divide);
// one result with value, derivative and status comes out per item, in
// order. Throughput is one item per cycle while m_ready does not hold the
// pipeline. Stages: input register, product stage, combine stage,
// divider set-up, one restoring divider step per quotient bit (33 bits,
// two lanes side by side for value and derivative), and output register.
// All stages advance together; while a result waits on m_ready the whole
// pipeline holds and s_ready is low. Status is 0 ok, 1 saturated, 2 divide
// by zero (both outputs zero).
`include "assert_macros.svh"

module dual_number_alu_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  logic [1:0]                             s_action,
    input  logic signed [dna_pkg::WORD_BITS-1:0]   s_a_real,
    input  logic signed [dna_pkg::WORD_BITS-1:0]   s_a_deriv,
    input  logic signed [dna_pkg::WORD_BITS-1:0]   s_b_real,
    input  logic signed [dna_pkg::WORD_BITS-1:0]   s_b_deriv,
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output logic signed [dna_pkg::WORD_BITS-1:0]   m_out_real,
    output logic signed [dna_pkg::WORD_BITS-1:0]   m_out_deriv,
    output logic [1:0]                             m_status
);

    localparam int W  = dna_pkg::WORD_BITS;
    localparam int PB = dna_pkg::PROD_BITS;
    localparam int WB = dna_pkg::WIDE_BITS;
    localparam int MB = dna_pkg::MAG_BITS;
    localparam int NB = dna_pkg::NUM_BITS;
    localparam int DB = dna_pkg::DEN_BITS;
    localparam int QB = dna_pkg::QUO_BITS;

    logic en;

    // Stage 1: input register
    logic                  s1_valid_reg;
    dna_pkg::op_t          s1_op_reg;
    logic signed [W-1:0]   s1_ar_reg, s1_ad_reg, s1_br_reg, s1_bd_reg;

    // Stage 2: products, sums, magnitudes
    logic                  s2_valid_reg;
    dna_pkg::op_t          s2_op_reg;
    logic signed [PB-1:0]  s2_pp0_reg, s2_pp1_reg, s2_pp2_reg, s2_pp3_reg;
    dna_pkg::clamp_t       s2_asv_reg, s2_asd_reg;
    logic                  s2_neg_reg, s2_bzero_reg;
    logic [MB-1:0]         s2_armag_reg, s2_brmag_reg;

    // Stage 3: combined results and divider operands
    logic                  s3_valid_reg;
    dna_pkg::carry_t       s3_carry_reg, s3_carry_next;
    dna_pkg::nlane_t       s3_lane_reg [2];
    dna_pkg::nlane_t       s3_lane_next [2];

    // Divider stages: index 0 is set-up, index i+1 follows step i
    logic                  dv_valid_reg [QB+1];
    dna_pkg::carry_t       dv_carry_reg [QB+1];
    dna_pkg::lane_t        dv_lane_reg  [QB+1][2];

    // Output register
    logic                  m_valid_reg;
    logic signed [W-1:0]   m_real_reg, m_deriv_reg;
    dna_pkg::status_t      m_status_reg;

    dna_pkg::clamp_t       fin0, fin1;
    dna_pkg::carry_t       last_carry;

    logic                  chk_divz, chk_sat, chk_zero, chk_extreme;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Capture the input transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= s_valid;
        end
        if (en) begin
            s1_op_reg <= dna_pkg::op_t'(s_action);
            s1_ar_reg <= s_a_real;
            s1_ad_reg <= s_a_deriv;
            s1_br_reg <= s_b_real;
            s1_bd_reg <= s_b_deriv;
        end
    end

    // Form products, add or subtract, and magnitudes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (en) begin
            s2_op_reg  <= s1_op_reg;
            s2_pp0_reg <= PB'(s1_ar_reg) * PB'(s1_br_reg);
            s2_pp1_reg <= PB'(s1_ar_reg) * PB'(s1_bd_reg);
            s2_pp2_reg <= PB'(s1_ad_reg) * PB'(s1_br_reg);
            s2_pp3_reg <= PB'(s1_br_reg) * PB'(s1_br_reg);
            if (s1_op_reg == dna_pkg::OP_SUB) begin
                s2_asv_reg <= dna_pkg::clamp_word(WB'(s1_ar_reg) - WB'(s1_br_reg));
                s2_asd_reg <= dna_pkg::clamp_word(WB'(s1_ad_reg) - WB'(s1_bd_reg));
            end else begin
                s2_asv_reg <= dna_pkg::clamp_word(WB'(s1_ar_reg) + WB'(s1_br_reg));
                s2_asd_reg <= dna_pkg::clamp_word(WB'(s1_ad_reg) + WB'(s1_bd_reg));
            end
            s2_neg_reg   <= s1_ar_reg[W-1] ^ s1_br_reg[W-1];
            s2_bzero_reg <= (s1_br_reg == '0);
            s2_armag_reg <= dna_pkg::word_mag(s1_ar_reg);
            s2_brmag_reg <= dna_pkg::word_mag(s1_br_reg);
        end
    end

    // Combine products into results, prepare division lanes
    always_comb begin
        logic signed [WB-1:0] wr;
        logic signed [WB-1:0] ws;
        logic signed [WB-1:0] num;
        logic [WB-1:0]        nmag;
        dna_pkg::clamp_t      cr;
        dna_pkg::clamp_t      cd;
        wr   = WB'(s2_pp0_reg);
        ws   = WB'(s2_pp1_reg) + WB'(s2_pp2_reg);
        num  = WB'(s2_pp2_reg) - WB'(s2_pp1_reg);
        nmag = num[WB-1] ? (~num + 1'b1) : num;
        cr   = dna_pkg::clamp_word(wr >>> dna_pkg::FRAC_BITS);
        cd   = dna_pkg::clamp_word(ws >>> dna_pkg::FRAC_BITS);

        s3_carry_next = '0;
        case (s2_op_reg) inside
            dna_pkg::OP_ADD, dna_pkg::OP_SUB: begin
                s3_carry_next.val    = s2_asv_reg.val;
                s3_carry_next.der    = s2_asd_reg.val;
                s3_carry_next.status = (s2_asv_reg.sat || s2_asd_reg.sat) ?
                                       dna_pkg::ST_SAT : dna_pkg::ST_OK;
            end
            dna_pkg::OP_MUL: begin
                s3_carry_next.val    = cr.val;
                s3_carry_next.der    = cd.val;
                s3_carry_next.status = (cr.sat || cd.sat) ? dna_pkg::ST_SAT : dna_pkg::ST_OK;
            end
            default: begin
                if (s2_bzero_reg) begin
                    s3_carry_next.status = dna_pkg::ST_DIVZ;
                end else begin
                    s3_carry_next.is_div = 1'b1;
                end
            end
        endcase

        s3_lane_next[0].numr = NB'(s2_armag_reg) << dna_pkg::FRAC_BITS;
        s3_lane_next[0].den  = DB'(s2_brmag_reg);
        s3_lane_next[0].neg  = s2_neg_reg;
        s3_lane_next[1].numr = NB'(nmag[PB-1:0]) << dna_pkg::FRAC_BITS;
        s3_lane_next[1].den  = s2_pp3_reg;
        s3_lane_next[1].neg  = num[WB-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (en) begin
            s3_valid_reg <= s2_valid_reg;
        end
        if (en) begin
            s3_carry_reg   <= s3_carry_next;
            s3_lane_reg[0] <= s3_lane_next[0];
            s3_lane_reg[1] <= s3_lane_next[1];
        end
    end

    // Advance the divider: set-up, then one quotient bit per stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i <= QB; i++) begin
                dv_valid_reg[i] <= 1'b0;
            end
        end else if (en) begin
            dv_valid_reg[0] <= s3_valid_reg;
            for (int i = 0; i < QB; i++) begin
                dv_valid_reg[i+1] <= dv_valid_reg[i];
            end
        end
        if (en) begin
            dv_carry_reg[0]   <= s3_carry_reg;
            dv_lane_reg[0][0] <= dna_pkg::div_init(s3_lane_reg[0]);
            dv_lane_reg[0][1] <= dna_pkg::div_init(s3_lane_reg[1]);
            for (int i = 0; i < QB; i++) begin
                dv_carry_reg[i+1]   <= dv_carry_reg[i];
                dv_lane_reg[i+1][0] <= dna_pkg::div_step(dv_lane_reg[i][0]);
                dv_lane_reg[i+1][1] <= dna_pkg::div_step(dv_lane_reg[i][1]);
            end
        end
    end

    // Select the result and hold it until transferred
    assign fin0       = dna_pkg::div_finish(dv_lane_reg[QB][0]);
    assign fin1       = dna_pkg::div_finish(dv_lane_reg[QB][1]);
    assign last_carry = dv_carry_reg[QB];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_valid_reg[QB];
        end
        if (en) begin
            if (last_carry.is_div) begin
                m_real_reg   <= fin0.val;
                m_deriv_reg  <= fin1.val;
                m_status_reg <= (fin0.sat || fin1.sat) ? dna_pkg::ST_SAT : dna_pkg::ST_OK;
            end else begin
                m_real_reg   <= last_carry.val;
                m_deriv_reg  <= last_carry.der;
                m_status_reg <= last_carry.status;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_real  = m_real_reg;
    assign m_out_deriv = m_deriv_reg;
    assign m_status    = m_status_reg;

    // Checks
    assign chk_divz    = m_valid && (m_status == dna_pkg::ST_DIVZ);
    assign chk_sat     = m_valid && (m_status == dna_pkg::ST_SAT);
    assign chk_zero    = (m_out_real == '0) && (m_out_deriv == '0);
    assign chk_extreme = (m_out_real == dna_pkg::WORD_MAX_C)
                      || (m_out_real == dna_pkg::WORD_MIN_C)
                      || (m_out_deriv == dna_pkg::WORD_MAX_C)
                      || (m_out_deriv == dna_pkg::WORD_MIN_C);

    `ASSERT_CLK(a_divz_zero, aclk, aresetn, chk_divz |-> chk_zero)
    `ASSERT_CLK(a_sat_extreme, aclk, aresetn, chk_sat |-> chk_extreme)
    `ASSERT_CLK(a_stall_blocks, aclk, aresetn, (m_valid && !m_ready) |-> !s_ready)

endmodule
